/* hw/rtl/peer_address_table_defines.svh */
// Assertion macros used by the checker file.
`ifndef PEER_ADDRESS_TABLE_DEFINES_SVH
`define PEER_ADDRESS_TABLE_DEFINES_SVH

// Same-cycle implication, clocked on the rising edge, off during reset.
`define PAT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on the rising edge, off during reset.
`define PAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/pat_pkg.sv */
package pat_pkg;

   localparam int DefaultEntries = 16;
   localparam int MacWidth       = 48;
   localparam int RoleWidth      = 8;
   localparam int RssiWidth      = 8;
   localparam int TimeWidth      = 32;
   localparam int SlotWidth      = 4;
   localparam int CountWidth     = 5;
   localparam int TypeWidth      = 3;

   localparam logic signed [RssiWidth-1:0] RssiNever = -8'sd128;
   localparam logic signed [RssiWidth-1:0] RssiFloor = -8'sd127;

   typedef enum logic [TypeWidth-1:0] {
      REQ_ADD       = 3'd0,
      REQ_REMOVE    = 3'd1,
      REQ_SET_ROLE  = 3'd2,
      REQ_SEEN      = 3'd3,
      REQ_LOOKUP    = 3'd4,
      REQ_READ_SLOT = 3'd5
   } req_code_type;

   typedef struct packed {
      logic [TypeWidth-1:0]        req_type;
      logic [MacWidth-1:0]         mac;
      logic [RoleWidth-1:0]        role;
      logic signed [RssiWidth-1:0] rssi;
      logic [TimeWidth-1:0]        now_ms;
      logic [SlotWidth-1:0]        slot_index;
   } request_type;

   typedef struct packed {
      logic [MacWidth-1:0]         mac;
      logic [RoleWidth-1:0]        role;
      logic signed [RssiWidth-1:0] rssi;
      logic [TimeWidth-1:0]        seen;
   } entry_type;

   typedef struct packed {
      logic                        ok;
      logic [SlotWidth-1:0]        hit_slot;
      logic [MacWidth-1:0]         mac_out;
      logic [RoleWidth-1:0]        role_out;
      logic signed [RssiWidth-1:0] rssi_out;
      logic [TimeWidth-1:0]        seen_ms_out;
      logic [CountWidth-1:0]       count;
   } result_type;

endpackage

/* hw/rtl/pat_ifs.sv */
interface pat_req_if;
   logic                                        valid;
   logic                                        ready;
   logic [pat_pkg::TypeWidth-1:0]               req_type;
   logic [pat_pkg::MacWidth-1:0]                mac;
   logic [pat_pkg::RoleWidth-1:0]               role;
   logic signed [pat_pkg::RssiWidth-1:0]        rssi;
   logic [pat_pkg::TimeWidth-1:0]               now_ms;
   logic [pat_pkg::SlotWidth-1:0]               slot_index;

   modport source (output valid, req_type, mac, role, rssi, now_ms, slot_index,
                   input ready);
   modport sink (input valid, req_type, mac, role, rssi, now_ms, slot_index,
                 output ready);
endinterface

interface pat_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic                                        ok;
   logic [pat_pkg::SlotWidth-1:0]               hit_slot;
   logic [pat_pkg::MacWidth-1:0]                mac_out;
   logic [pat_pkg::RoleWidth-1:0]               role_out;
   logic signed [pat_pkg::RssiWidth-1:0]        rssi_out;
   logic [pat_pkg::TimeWidth-1:0]               seen_ms_out;
   logic [pat_pkg::CountWidth-1:0]              count;

   modport source (output valid, ok, hit_slot, mac_out, role_out, rssi_out, seen_ms_out,
                   count, input ready);
   modport sink (input valid, ok, hit_slot, mac_out, role_out, rssi_out, seen_ms_out,
                 count, output ready);
endinterface

/* hw/rtl/peer_address_table.sv */
// Peer address table: up to ENTRIES peers keyed by 48-bit MAC, packed densely in
// slots 0 to count-1 of one table memory with one write port and a registered read
// port. One request is worked on at a time. A keyed request (add, remove, set role,
// seen update, lookup) scans the table one entry per cycle until the MAC matches or
// the table ends, then does its update in ST_ACT; a remove that frees a slot other
// than the last moves the last entry into it in ST_MOVE. ST_DONE then hands the
// beat to the output register once that register can take it. A read by slot passes
// through ST_READ to ST_DONE; a slot at or above count goes straight to ST_DONE, as
// does an unknown request type. The output register holds a finished beat while the
// next request is already accepted. The table needs no clearing after reset; only
// slots below count are ever read.
module peer_address_table #(
   parameter int ENTRIES = pat_pkg::DefaultEntries
) (
   input logic       clock,
   input logic       reset,
   pat_req_if.sink   req_bus,
   pat_rsp_if.source rsp_bus
);
   import pat_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   request_type req;
   result_type  res;
   logic        res_valid;
   logic        res_ready;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   entry_type   wr_data;
   entry_type   rd_data;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   assign req = '{req_type: req_bus.req_type, mac: req_bus.mac, role: req_bus.role,
                  rssi: req_bus.rssi, now_ms: req_bus.now_ms,
                  slot_index: req_bus.slot_index};

   pat_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pat_engine #(.ENTRIES(ENTRIES), .AW(AW), .CW(CW)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req       (req),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.ok          = rsp_data_ff.ok;
   assign rsp_bus.hit_slot    = rsp_data_ff.hit_slot;
   assign rsp_bus.mac_out     = rsp_data_ff.mac_out;
   assign rsp_bus.role_out    = rsp_data_ff.role_out;
   assign rsp_bus.rssi_out    = rsp_data_ff.rssi_out;
   assign rsp_bus.seen_ms_out = rsp_data_ff.seen_ms_out;
   assign rsp_bus.count       = rsp_data_ff.count;

endmodule

/* hw/rtl/pat_mem.sv */
module pat_mem #(
   parameter int ENTRIES = pat_pkg::DefaultEntries,
   parameter int AW      = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  pat_pkg::entry_type  wr_data,
   input  logic [AW-1:0]       rd_addr,
   output pat_pkg::entry_type  rd_data
);
   import pat_pkg::*;

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/pat_engine.sv */
module pat_engine #(
   parameter int ENTRIES = pat_pkg::DefaultEntries,
   parameter int AW      = 4,
   parameter int CW      = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pat_pkg::request_type req,
   output logic                 res_valid,
   input  logic                 res_ready,
   output pat_pkg::result_type  res,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output pat_pkg::entry_type   wr_data,
   output logic [AW-1:0]        rd_addr,
   input  pat_pkg::entry_type   rd_data
);
   import pat_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_READ, ST_ACT, ST_MOVE, ST_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic        found_ff, found_in;
   logic [AW-1:0] slot_ff, slot_in;
   request_type req_ff, req_in;
   entry_type   ent_ff, ent_in;
   result_type  res_ff, res_in;

   entry_type   upd;
   logic [CW-1:0] idx_next;
   logic [CW-1:0] last;
   logic        room;
   logic signed [RssiWidth-1:0] rssi_sat;

   function automatic result_type report(logic [AW-1:0] s, entry_type e);
      result_type r;
      r             = '0;
      r.ok          = 1'b1;
      r.hit_slot    = SlotWidth'(s);
      r.mac_out     = e.mac;
      r.role_out    = e.role;
      r.rssi_out    = e.rssi;
      r.seen_ms_out = e.seen;
      return r;
   endfunction

   assign idx_next = CW'(idx_ff + 1'b1);
   assign last     = CW'(count_ff - 1'b1);
   assign room     = count_ff < CW'(ENTRIES);
   assign rssi_sat = (req_ff.rssi == RssiNever) ? RssiFloor : req_ff.rssi;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      found_in  = found_ff;
      slot_in   = slot_ff;
      req_in    = req_ff;
      ent_in    = ent_ff;
      res_in    = res_ff;
      upd       = ent_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = slot_ff;
      wr_data   = ent_ff;
      rd_addr   = '0;
      res       = res_ff;
      res.count = CountWidth'(count_ff);

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req;
               res_in   = '0;
               found_in = 1'b0;
               idx_in   = '0;
               unique case (req.req_type) inside
                  REQ_READ_SLOT: begin
                     if (32'(req.slot_index) < 32'(count_ff)) begin
                        rd_addr  = AW'(req.slot_index);
                        slot_in  = AW'(req.slot_index);
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  REQ_ADD, REQ_REMOVE, REQ_SET_ROLE, REQ_SEEN, REQ_LOOKUP: begin
                     if (count_ff == '0) begin
                        state_in = ST_ACT;
                     end else begin
                        rd_addr  = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_data.mac == req_ff.mac) begin
               found_in = 1'b1;
               slot_in  = idx_ff[AW-1:0];
               ent_in   = rd_data;
               state_in = ST_ACT;
            end else if (idx_next < count_ff) begin
               rd_addr = idx_next[AW-1:0];
               idx_in  = idx_next;
            end else begin
               state_in = ST_ACT;
            end
         end
         ST_READ: begin
            res_in   = report(slot_ff, rd_data);
            state_in = ST_DONE;
         end
         ST_ACT: begin
            state_in = ST_DONE;
            unique case (req_ff.req_type)
               REQ_ADD: begin
                  if (found_ff) begin
                     upd.role = req_ff.role;
                     wr_en    = 1'b1;
                     wr_data  = upd;
                     res_in   = report(slot_ff, upd);
                  end else if (room) begin
                     upd      = '{mac: req_ff.mac, role: req_ff.role, rssi: RssiNever, seen: '0};
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     wr_data  = upd;
                     res_in   = report(count_ff[AW-1:0], upd);
                     count_in = CW'(count_ff + 1'b1);
                  end
               end
               REQ_REMOVE: begin
                  if (found_ff) begin
                     res_in = report(slot_ff, ent_ff);
                     if (slot_ff != last[AW-1:0]) begin
                        rd_addr  = last[AW-1:0];
                        state_in = ST_MOVE;
                     end else begin
                        count_in = last;
                     end
                  end
               end
               REQ_SET_ROLE: begin
                  if (found_ff) begin
                     upd.role = req_ff.role;
                     wr_en    = 1'b1;
                     wr_data  = upd;
                     res_in   = report(slot_ff, upd);
                  end
               end
               REQ_SEEN: begin
                  if (found_ff) begin
                     upd.rssi = rssi_sat;
                     upd.seen = req_ff.now_ms;
                     wr_en    = 1'b1;
                     wr_data  = upd;
                     res_in   = report(slot_ff, upd);
                  end else if (room) begin
                     upd      = '{mac: req_ff.mac, role: '0, rssi: rssi_sat,
                                  seen: req_ff.now_ms};
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     wr_data  = upd;
                     res_in   = report(count_ff[AW-1:0], upd);
                     count_in = CW'(count_ff + 1'b1);
                  end
               end
               REQ_LOOKUP: begin
                  if (found_ff) begin
                     res_in = report(slot_ff, ent_ff);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_MOVE: begin
            // fill the hole with the last entry
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = rd_data;
            count_in = last;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff   <= idx_in;
      found_ff <= found_in;
      slot_ff  <= slot_in;
      req_ff   <= req_in;
      ent_ff   <= ent_in;
      res_ff   <= res_in;
   end

endmodule

/* hw/rtl/pat_checker.sv */
`include "peer_address_table_defines.svh"

module pat_checker #(
   parameter int ENTRIES = pat_pkg::DefaultEntries
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_ok,
   input logic [pat_pkg::SlotWidth-1:0]        rsp_hit_slot,
   input logic [pat_pkg::MacWidth-1:0]         rsp_mac_out,
   input logic [pat_pkg::RoleWidth-1:0]        rsp_role_out,
   input logic signed [pat_pkg::RssiWidth-1:0] rsp_rssi_out,
   input logic [pat_pkg::TimeWidth-1:0]        rsp_seen_ms_out,
   input logic [pat_pkg::CountWidth-1:0]       rsp_count
);
   import pat_pkg::*;

   // hold a stalled response beat
   `PAT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_mac_out) && $stable(rsp_count) && $stable(rsp_ok), "stalled response beat changed")

   `PAT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request accepted while another is in flight")

   `PAT_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && !rsp_ok, rsp_hit_slot == '0 && rsp_mac_out == '0 && rsp_role_out == '0 && rsp_rssi_out == '0 && rsp_seen_ms_out == '0, "failed response carries entry data")

   `PAT_ASSERT_NOW(a_count_range, clock, reset, rsp_valid, 32'(rsp_count) <= ENTRIES, "count above table size")

endmodule

bind peer_address_table pat_checker #(.ENTRIES(ENTRIES)) u_pat_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_ok          (rsp_bus.ok),
   .rsp_hit_slot    (rsp_bus.hit_slot),
   .rsp_mac_out     (rsp_bus.mac_out),
   .rsp_role_out    (rsp_bus.role_out),
   .rsp_rssi_out    (rsp_bus.rssi_out),
   .rsp_seen_ms_out (rsp_bus.seen_ms_out),
   .rsp_count       (rsp_bus.count)
);

/* bench/peer_table_watch.sv */
`timescale 1ns / 100ps

module peer_table_watch #(
   parameter int ENTRIES = pat_pkg::DefaultEntries
) (
   input  logic clock,
   input  logic reset,
   pat_req_if   req_bus,
   pat_rsp_if   rsp_bus,
   output int   mismatches,
   output int   due_count
);
   import pat_pkg::*;

   logic [MacWidth-1:0]         mac_tab  [ENTRIES];
   logic [RoleWidth-1:0]        role_tab [ENTRIES];
   logic signed [RssiWidth-1:0] rssi_tab [ENTRIES];
   logic [TimeWidth-1:0]        seen_tab [ENTRIES];
   int                          used = 0;
   result_type                  due_results [$];

   initial begin
      mismatches = 0;
      due_count  = 0;
   end

   task automatic note_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         note_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
      end
   endtask

   function automatic int find_peer(input logic [MacWidth-1:0] mac);
      int hit;
      hit = -1;
      for (int i = 0; i < used; i++) begin
         if (hit < 0 && mac_tab[i] == mac) begin
            hit = i;
         end
      end
      return hit;
   endfunction

   function automatic int append_peer(input logic [MacWidth-1:0] mac,
                                      input logic [RoleWidth-1:0] role);
      int slot;
      slot = -1;
      if (used < ENTRIES) begin
         slot           = used;
         mac_tab[slot]  = mac;
         role_tab[slot] = role;
         rssi_tab[slot] = RssiNever;
         seen_tab[slot] = '0;
         used++;
      end
      return slot;
   endfunction

   function automatic result_type entry_view(input int slot);
      result_type r;
      r             = '0;
      r.ok          = 1'b1;
      r.hit_slot    = SlotWidth'(slot);
      r.mac_out     = mac_tab[slot];
      r.role_out    = role_tab[slot];
      r.rssi_out    = rssi_tab[slot];
      r.seen_ms_out = seen_tab[slot];
      return r;
   endfunction

   function automatic result_type apply_to_table(input request_type q);
      result_type r;
      int         slot;
      int         last;
      r    = '0;
      slot = find_peer(q.mac);
      case (q.req_type)
         REQ_ADD: begin
            if (slot >= 0) begin
               role_tab[slot] = q.role;
            end else begin
               slot = append_peer(q.mac, q.role);
            end
            if (slot >= 0) begin
               r = entry_view(slot);
            end
         end
         REQ_REMOVE: begin
            if (slot >= 0) begin
               r              = entry_view(slot);
               last           = used - 1;
               mac_tab[slot]  = mac_tab[last];
               role_tab[slot] = role_tab[last];
               rssi_tab[slot] = rssi_tab[last];
               seen_tab[slot] = seen_tab[last];
               used--;
            end
         end
         REQ_SET_ROLE: begin
            if (slot >= 0) begin
               role_tab[slot] = q.role;
               r              = entry_view(slot);
            end
         end
         REQ_SEEN: begin
            if (slot < 0) begin
               slot = append_peer(q.mac, '0);
            end
            if (slot >= 0) begin
               rssi_tab[slot] = (q.rssi == RssiNever) ? RssiFloor : q.rssi;
               seen_tab[slot] = q.now_ms;
               r              = entry_view(slot);
            end
         end
         REQ_LOOKUP: begin
            if (slot >= 0) begin
               r = entry_view(slot);
            end
         end
         REQ_READ_SLOT: begin
            if (int'(q.slot_index) < used) begin
               r = entry_view(int'(q.slot_index));
            end
         end
         default: begin
         end
      endcase
      r.count = CountWidth'(used);
      return r;
   endfunction

   always @(posedge clock) begin
      request_type q;
      result_type  got;
      result_type  want;
      if (reset) begin
         used = 0;
         due_results.delete();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            q.req_type   = req_bus.req_type;
            q.mac        = req_bus.mac;
            q.role       = req_bus.role;
            q.rssi       = req_bus.rssi;
            q.now_ms     = req_bus.now_ms;
            q.slot_index = req_bus.slot_index;
            due_results.push_back(apply_to_table(q));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.ok          = rsp_bus.ok;
            got.hit_slot    = rsp_bus.hit_slot;
            got.mac_out     = rsp_bus.mac_out;
            got.role_out    = rsp_bus.role_out;
            got.rssi_out    = rsp_bus.rssi_out;
            got.seen_ms_out = rsp_bus.seen_ms_out;
            got.count       = rsp_bus.count;
            if (due_results.size() == 0) begin
               note_mismatch("result beat with no request outstanding");
            end else begin
               want = due_results.pop_front();
               check_field("ok", got.ok, want.ok);
               check_field("hit_slot", got.hit_slot, want.hit_slot);
               check_field("mac_out", got.mac_out, want.mac_out);
               check_field("role_out", got.role_out, want.role_out);
               check_field("rssi_out", got.rssi_out, want.rssi_out);
               check_field("seen_ms_out", got.seen_ms_out, want.seen_ms_out);
               check_field("count", got.count, want.count);
            end
         end
      end
      due_count <= due_results.size();
   end

endmodule

/* bench/peer_address_table_tb.sv */
`timescale 1ns / 100ps

module peer_address_table_tb;
   import pat_pkg::*;

   localparam logic [TypeWidth-1:0] ReqSpareLo = 3'd6;
   localparam logic [TypeWidth-1:0] ReqSpareHi = 3'd7;
   localparam int PoolSize      = 24;
   localparam int LongHold      = 300;
   localparam int PhaseItems    = 306;
   localparam int DrainCycles   = 40;
   localparam int PhaseSend [4] = '{0, 59, 0, 24};
   localparam int PhaseStall[4] = '{0, 0, 59, 24};

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   stall_pct = 0;
   int   hold_asks = 0;
   int   holds_served = 0;
   int   hold_left = 0;
   int   mismatches;
   int   due_count;
   logic [MacWidth-1:0] mac_pool [PoolSize];

   pat_req_if req_bus();
   pat_rsp_if rsp_bus();

   peer_address_table uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   peer_table_watch table_watch (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .mismatches (mismatches),
      .due_count  (due_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_served) begin
            holds_served = hold_asks;
            hold_left    = LongHold;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic request_type make_req(input logic [TypeWidth-1:0] kind,
                                            input logic [MacWidth-1:0] mac,
                                            input logic [RoleWidth-1:0] role,
                                            input logic signed [RssiWidth-1:0] rssi,
                                            input logic [TimeWidth-1:0] now_ms,
                                            input logic [SlotWidth-1:0] slot_index);
      return '{kind, mac, role, rssi, now_ms, slot_index};
   endfunction

   function automatic request_type draw_request(input int pool_n);
      request_type q;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 24) q.req_type = REQ_ADD;
      else if (pick < 38) q.req_type = REQ_REMOVE;
      else if (pick < 48) q.req_type = REQ_SET_ROLE;
      else if (pick < 68) q.req_type = REQ_SEEN;
      else if (pick < 80) q.req_type = REQ_LOOKUP;
      else if (pick < 94) q.req_type = REQ_READ_SLOT;
      else if (pick < 97) q.req_type = ReqSpareLo;
      else q.req_type = ReqSpareHi;
      if ($urandom_range(99) < 88) begin
         q.mac = mac_pool[$urandom_range(pool_n - 1)];
      end else begin
         q.mac = {16'($urandom), $urandom};
      end
      q.role = RoleWidth'($urandom_range(255));
      if ($urandom_range(9) == 0) begin
         q.rssi = RssiNever;
      end else begin
         q.rssi = RssiWidth'($urandom_range(255));
      end
      q.now_ms     = ($urandom_range(19) == 0) ? '1 : $urandom;
      q.slot_index = SlotWidth'($urandom_range(15));
      return q;
   endfunction

   task automatic offer(input request_type q);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= q.req_type;
      req_bus.mac        <= q.mac;
      req_bus.role       <= q.role;
      req_bus.rssi       <= q.rssi;
      req_bus.now_ms     <= q.now_ms;
      req_bus.slot_index <= q.slot_index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (due_count != 0) @(posedge clock);
   endtask

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_ADD;
      req_bus.mac        <= '0;
      req_bus.role       <= '0;
      req_bus.rssi       <= '0;
      req_bus.now_ms     <= '0;
      req_bus.slot_index <= '0;
      mac_pool[0] = '0;
      mac_pool[1] = '1;
      for (int i = 2; i < PoolSize; i++) begin
         mac_pool[i] = {16'($urandom), $urandom};
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      offer(make_req(REQ_LOOKUP, '0, '0, '0, '0, '0));
      offer(make_req(REQ_READ_SLOT, '0, '0, '0, '0, '0));
      offer(make_req(REQ_REMOVE, 48'h5, '0, '0, '0, '0));
      offer(make_req(REQ_SET_ROLE, '1, 8'h11, '0, '0, '0));
      offer(make_req(REQ_ADD, '0, '0, '0, '0, '0));
      offer(make_req(REQ_ADD, '1, '1, '0, '0, '1));
      offer(make_req(REQ_ADD, '0, 8'hA5, '0, '0, '0));
      offer(make_req(REQ_SEEN, '1, '0, RssiNever, '1, '0));
      offer(make_req(REQ_SEEN, '0, '0, 8'sd127, '0, '0));
      offer(make_req(REQ_SEEN, 48'h0123_4567_89AB, 8'h77, -8'sd1, 32'd1234, '0));
      offer(make_req(REQ_SET_ROLE, '1, 8'h5A, '0, '0, '0));
      offer(make_req(REQ_LOOKUP, 48'h0123_4567_89AB, '0, '0, '0, '0));
      offer(make_req(REQ_READ_SLOT, '0, '0, '0, '0, 4'd2));
      offer(make_req(REQ_READ_SLOT, '0, '0, '0, '0, 4'd3));
      offer(make_req(REQ_READ_SLOT, '0, '0, '0, '0, '1));
      offer(make_req(ReqSpareLo, '0, '1, '1, '1, '1));
      offer(make_req(ReqSpareHi, '1, '1, '1, '1, '1));
      offer(make_req(REQ_LOOKUP, 48'hFFFF_0000_FFFF, '0, '0, '0, '0));
      offer(make_req(REQ_REMOVE, '0, '0, '0, '0, '0));
      offer(make_req(REQ_READ_SLOT, '0, '0, '0, '0, '0));
      offer(make_req(REQ_REMOVE, '1, '0, '0, '0, '0));
      offer(make_req(REQ_REMOVE, 48'h0123_4567_89AB, '0, '0, '0, '0));
      offer(make_req(REQ_SEEN, 48'hAAAA_5555_AAAA, 8'hC3, 8'sd1, 32'h5555_AAAA, '0));
      settle();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = PhaseSend[p];
         stall_pct     = PhaseStall[p];
         for (int n = 0; n < PhaseItems; n++) begin
            if (p == 0 && n == 150) begin
               hold_asks++;
            end
            offer(draw_request(n < 102 ? PoolSize : (n < 204 ? 12 : 3)));
         end
         settle();
      end

      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && due_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
